@@ design/jsu_pkg.sv @@
package jsu_pkg;

    localparam logic [1:0] ST_OPEN = 2'd0;
    localparam logic [1:0] ST_DONE = 2'd1;
    localparam logic [1:0] ST_ERR  = 2'd2;

    localparam logic [1:0] ROWS_ONE   = 2'd0;
    localparam logic [1:0] ROWS_TWO   = 2'd1;
    localparam logic [1:0] ROWS_THREE = 2'd2;

    typedef struct packed {
        logic [2:0][7:0] bytes;
        logic [1:0]      last_row;
        logic            byte_valid;
        logic [1:0]      status;
    } t_cmd;

endpackage

@@ design/jsu_front.sv @@
module jsu_front
    import jsu_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,
    input  logic       s_axis_tlast,
    output logic       o_push,
    output t_cmd       o_cmd,
    input  logic       i_full
);

    typedef enum logic [2:0] {
        PH_IDLE = 3'd0,
        PH_STR  = 3'd1,
        PH_ESC  = 3'd2,
        PH_HEX1 = 3'd3,
        PH_HEX2 = 3'd4,
        PH_HEX3 = 3'd5,
        PH_HEX4 = 3'd6
    } t_phase;

    t_phase      r_phase, n_phase;
    logic [15:0] r_accum, n_accum;

    logic [7:0]  c;
    logic        eoi;
    logic        hex_ok;
    logic [3:0]  hex_d;
    logic        esc_ok;
    logic [7:0]  esc_b;
    logic [15:0] code;
    logic        acc;

    assign c             = s_axis_tdata;
    assign eoi           = s_axis_tlast;
    assign s_axis_tready = !i_full;
    assign acc           = s_axis_tvalid && !i_full;
    assign o_push        = acc;
    assign code          = {r_accum[11:0], hex_d};

    always_comb begin
        hex_ok = 1'b1;
        hex_d  = 4'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            hex_d = c[3:0];
        end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
            hex_d = c[3:0] + 4'd9;
        end else begin
            hex_ok = 1'b0;
        end
    end

    always_comb begin
        esc_ok = 1'b1;
        case (c)
            8'h22:   esc_b = 8'h22;
            8'h5C:   esc_b = 8'h5C;
            8'h2F:   esc_b = 8'h2F;
            8'h62:   esc_b = 8'h08;
            8'h66:   esc_b = 8'h0C;
            8'h6E:   esc_b = 8'h0A;
            8'h72:   esc_b = 8'h0D;
            8'h74:   esc_b = 8'h09;
            default: begin
                esc_ok = 1'b0;
                esc_b  = 8'h00;
            end
        endcase
    end

    always_comb begin
        n_phase          = r_phase;
        n_accum          = r_accum;
        o_cmd.bytes      = '0;
        o_cmd.last_row   = ROWS_ONE;
        o_cmd.byte_valid = 1'b0;
        o_cmd.status     = ST_OPEN;
        unique case (r_phase)
            PH_STR: begin
                if (c == 8'h22) begin
                    o_cmd.status = ST_DONE;
                    n_phase      = PH_IDLE;
                end else if (eoi) begin
                    o_cmd.status = ST_ERR;
                    n_phase      = PH_IDLE;
                    n_accum      = '0;
                end else if (c == 8'h5C) begin
                    n_phase = PH_ESC;
                end else begin
                    o_cmd.bytes[0]   = c;
                    o_cmd.byte_valid = 1'b1;
                end
            end
            PH_ESC: begin
                if (c == 8'h75 && !eoi) begin
                    n_accum = '0;
                    n_phase = PH_HEX1;
                end else if (c != 8'h75 && esc_ok && !eoi) begin
                    o_cmd.bytes[0]   = esc_b;
                    o_cmd.byte_valid = 1'b1;
                    n_phase          = PH_STR;
                end else begin
                    o_cmd.status = ST_ERR;
                    n_phase      = PH_IDLE;
                    n_accum      = '0;
                end
            end
            PH_HEX1, PH_HEX2, PH_HEX3, PH_HEX4: begin
                if (!hex_ok || eoi) begin
                    o_cmd.status = ST_ERR;
                    n_phase      = PH_IDLE;
                    n_accum      = '0;
                end else if (r_phase != PH_HEX4) begin
                    n_accum = code;
                    n_phase = t_phase'(r_phase + 3'd1);
                end else begin
                    n_accum          = '0;
                    n_phase          = PH_STR;
                    o_cmd.byte_valid = 1'b1;
                    if (code < 16'h0080) begin
                        o_cmd.bytes[0] = code[7:0];
                    end else if (code < 16'h0800) begin
                        o_cmd.bytes[0] = 8'hC0 | {3'b000, code[10:6]};
                        o_cmd.bytes[1] = 8'h80 | {2'b00, code[5:0]};
                        o_cmd.last_row = ROWS_TWO;
                    end else begin
                        o_cmd.bytes[0] = 8'hE0 | {4'b0000, code[15:12]};
                        o_cmd.bytes[1] = 8'h80 | {2'b00, code[11:6]};
                        o_cmd.bytes[2] = 8'h80 | {2'b00, code[5:0]};
                        o_cmd.last_row = ROWS_THREE;
                    end
                end
            end
            default: begin
                if (c != 8'h22 || eoi) begin
                    o_cmd.status = ST_ERR;
                    n_phase      = PH_IDLE;
                    n_accum      = '0;
                end else begin
                    n_phase = PH_STR;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_accum <= '0;
        end else if (acc) begin
            r_phase <= n_phase;
            r_accum <= n_accum;
        end
    end

endmodule

@@ design/jsu_queue.sv @@
module jsu_queue
    import jsu_pkg::*;
#(
    parameter int DEPTH = 4
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    output logic o_full,
    output logic o_valid,
    output t_cmd o_cmd,
    input  logic i_pop
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    t_cmd          r_mem [DEPTH];
    logic [PW-1:0] r_wr_ptr, r_rd_ptr;
    logic [CW-1:0] r_count;
    logic          do_push, do_pop;

    assign o_full  = (r_count == FULL_CNT);
    assign o_valid = (r_count != '0);
    assign o_cmd   = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

@@ design/jsu_back.sv @@
module jsu_back
    import jsu_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  t_cmd        i_cmd,
    output logic        o_pop,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,
    output logic        m_axis_tuser,
    output logic        m_axis_tlast
);

    logic [1:0] r_row;
    logic       xfer;

    assign m_axis_tvalid = i_valid;
    assign m_axis_tdata  = {6'd0, i_cmd.status, i_cmd.bytes[r_row]};
    assign m_axis_tuser  = i_cmd.byte_valid;
    assign m_axis_tlast  = (r_row == i_cmd.last_row);
    assign xfer          = i_valid && m_axis_tready;
    assign o_pop         = xfer && m_axis_tlast;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row <= '0;
        end else if (xfer) begin
            r_row <= m_axis_tlast ? 2'd0 : r_row + 2'd1;
        end
    end

endmodule

@@ design/json_string_unescape.sv @@
// A transfer in is written into the queue, and its first result is driven from the queue head.
// Throughput: one input byte per cycle while each byte yields one result and the output is ready; a \uXXXX
// escape that closes into two or three UTF-8 bytes is sent as that many output rows.
// The queue absorbs short bursts; back-to-back three-byte escapes can fill it and stall input.
// The front phase logic, queue depth and output row counter set this behaviour.
// Reset: synchronous, active low; clears phase, hex accumulator, queue and row count.
module json_string_unescape
    import jsu_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // in_byte[7:0]
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // out_byte[7:0], status[9:8], zero[15:10]
    output logic        m_axis_tuser,   // byte_valid[0]
    output logic        m_axis_tlast
);

    logic push, full, q_valid, pop;
    t_cmd front_cmd, head_cmd;

    jsu_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .o_push        (push),
        .o_cmd         (front_cmd),
        .i_full        (full)
    );

    jsu_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (front_cmd),
        .o_full  (full),
        .o_valid (q_valid),
        .o_cmd   (head_cmd),
        .i_pop   (pop)
    );

    jsu_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (q_valid),
        .i_cmd         (head_cmd),
        .o_pop         (pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 100ps

module tb_top;
    import jsu_pkg::*;

    localparam int          TIMEOUT_CYCLES = 200000;
    localparam int          SETTLE_CYCLES  = 20;
    localparam logic [7:0]  CH_QUOTE       = 8'h22;
    localparam logic [7:0]  CH_BSLASH      = 8'h5C;
    localparam logic [7:0]  CH_U           = 8'h75;
    localparam logic [15:0] UTF8_TWO_MIN   = 16'h0080;
    localparam logic [15:0] UTF8_THREE_MIN = 16'h0800;

    typedef enum logic [2:0] {
        PH_IDLE = 3'd0,
        PH_STR  = 3'd1,
        PH_ESC  = 3'd2,
        PH_HEX1 = 3'd3,
        PH_HEX2 = 3'd4,
        PH_HEX3 = 3'd5,
        PH_HEX4 = 3'd6
    } t_phase;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       byte_valid;
        logic [1:0] status;
        logic       run_last;
    } t_row;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;   // in_byte[7:0]
    logic        s_axis_tlast;   // end_of_input
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [15:0] m_axis_tdata;   // out_byte[7:0], status[9:8], zero[15:10]
    logic        m_axis_tuser;   // byte_valid[0]
    logic        m_axis_tlast;   // run_last

    t_phase      dec_phase = PH_IDLE;
    logic [15:0] dec_accum = '0;
    t_row        expected_rows [$];
    t_row        exp_row;
    logic [7:0]  str_bytes [$];
    int          error_cnt     = 0;
    int          bytes_sent    = 0;
    int          cycle_cnt     = 0;
    int          send_idle_pct = 0;
    int          recv_idle_pct = 0;

    json_string_unescape u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > TIMEOUT_CYCLES) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    always @(negedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    function automatic int hex_digit(input logic [7:0] c);
        if (c >= "0" && c <= "9") return int'(c) - int'("0");
        if (c >= "a" && c <= "f") return int'(c) - int'("a") + 10;
        if (c >= "A" && c <= "F") return int'(c) - int'("A") + 10;
        return -1;
    endfunction

    function automatic int escape_value(input logic [7:0] c);
        case (c)
            CH_QUOTE:  return int'(CH_QUOTE);
            CH_BSLASH: return int'(CH_BSLASH);
            "/":       return int'("/");
            "b":       return int'(8'h08);
            "f":       return int'(8'h0C);
            "n":       return int'(8'h0A);
            "r":       return int'(8'h0D);
            "t":       return int'(8'h09);
            default:   return -1;
        endcase
    endfunction

    function automatic logic [7:0] escape_source(input int idx);
        case (idx)
            0:       return CH_QUOTE;
            1:       return CH_BSLASH;
            2:       return "/";
            3:       return "b";
            4:       return "f";
            5:       return "n";
            6:       return "r";
            default: return "t";
        endcase
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] nib, input logic upper);
        if (nib < 4'd10) return 8'("0") + 8'(nib);
        return (upper ? 8'("A") : 8'("a")) + 8'(nib) - 8'd10;
    endfunction

    task automatic add_row(input t_row row);
        expected_rows = {expected_rows, row};
    endtask

    task automatic add_byte(input logic [7:0] b);
        str_bytes = {str_bytes, b};
    endtask

    task automatic decode_byte(input logic [7:0] c, input logic eoi);
        logic [7:0]  obuf [3];
        int          n;
        int          d;
        int          m;
        int          k;
        logic [1:0]  st;
        logic [15:0] code;
        t_row        row;
        n    = 0;
        st   = ST_OPEN;
        d    = hex_digit(c);
        m    = escape_value(c);
        code = {dec_accum[11:0], d[3:0]};
        case (dec_phase)
            PH_STR: begin
                if (c == CH_QUOTE) begin
                    dec_phase = PH_IDLE;
                    st = ST_DONE;
                end else if (eoi) begin
                    st = ST_ERR;
                end else if (c == CH_BSLASH) begin
                    dec_phase = PH_ESC;
                end else begin
                    obuf[0] = c;
                    n = 1;
                end
            end
            PH_ESC: begin
                if (c == CH_U && !eoi) begin
                    dec_accum = '0;
                    dec_phase = PH_HEX1;
                end else if (m < 0 || eoi) begin
                    st = ST_ERR;
                end else begin
                    obuf[0] = m[7:0];
                    n = 1;
                    dec_phase = PH_STR;
                end
            end
            PH_HEX1, PH_HEX2, PH_HEX3, PH_HEX4: begin
                if (d < 0 || eoi) begin
                    st = ST_ERR;
                end else if (dec_phase != PH_HEX4) begin
                    dec_accum = code;
                    dec_phase = t_phase'(dec_phase + 3'd1);
                end else begin
                    dec_phase = PH_STR;
                    dec_accum = '0;
                    if (code < UTF8_TWO_MIN) begin
                        obuf[0] = code[7:0];
                        n = 1;
                    end else if (code < UTF8_THREE_MIN) begin
                        obuf[0] = {3'b110, code[10:6]};
                        obuf[1] = {2'b10, code[5:0]};
                        n = 2;
                    end else begin
                        obuf[0] = {4'b1110, code[15:12]};
                        obuf[1] = {2'b10, code[11:6]};
                        obuf[2] = {2'b10, code[5:0]};
                        n = 3;
                    end
                end
            end
            default: begin
                dec_phase = PH_IDLE;
                if (c != CH_QUOTE || eoi) st = ST_ERR;
                else dec_phase = PH_STR;
            end
        endcase
        if (st == ST_ERR) begin
            dec_phase = PH_IDLE;
            dec_accum = '0;
            n = 0;
        end
        if (n == 0) begin
            row = '{out_byte: 8'd0, byte_valid: 1'b0, status: st, run_last: 1'b1};
            add_row(row);
        end else begin
            for (k = 0; k < n; k++) begin
                row = '{out_byte: obuf[k], byte_valid: 1'b1, status: st,
                        run_last: (k == n - 1)};
                add_row(row);
            end
        end
    endtask

    // hold data until the transfer completes, then predict
    task automatic send_byte(input logic [7:0] b, input logic eoi);
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tlast  <= eoi;
        do @(posedge i_clk); while (!s_axis_tready);
        decode_byte(b, eoi);
        bytes_sent++;
    endtask

    task automatic drain_results;
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (expected_rows.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic add_segment;
        int          kind;
        int          range_sel;
        int          j;
        logic [7:0]  b;
        logic [15:0] code;
        kind = $urandom_range(6);
        if (kind <= 2) begin
            b = 8'($urandom_range(255));
            while (b == CH_QUOTE || b == CH_BSLASH) b = 8'($urandom_range(255));
            add_byte(b);
        end else if (kind <= 4) begin
            add_byte(CH_BSLASH);
            add_byte(escape_source(int'($urandom_range(7))));
        end else begin
            range_sel = $urandom_range(2);
            if (range_sel == 0) code = 16'($urandom_range(16'h007F));
            else if (range_sel == 1) code = 16'($urandom_range(16'h07FF, 16'h0080));
            else code = 16'($urandom_range(16'hFFFF, 16'h0800));
            add_byte(CH_BSLASH);
            add_byte(CH_U);
            for (j = 3; j >= 0; j--)
                add_byte(hex_char(code[j*4 +: 4], 1'($urandom_range(1))));
        end
    endtask

    // well-formed literals mostly; some truncated, corrupted or plain noise
    task automatic send_random_string;
        int   mode;
        int   cut;
        int   idx;
        int   i;
        logic eoi_at_cut;
        mode = $urandom_range(9);
        if (mode == 9) begin
            repeat ($urandom_range(3, 1))
                send_byte(8'($urandom_range(255)), $urandom_range(7) == 0);
        end else begin
            str_bytes.delete();
            add_byte(CH_QUOTE);
            repeat ($urandom_range(6)) add_segment();
            add_byte(CH_QUOTE);
            cut = str_bytes.size() - 1;
            eoi_at_cut = (mode == 6);
            if (mode == 7) begin
                cut = $urandom_range(str_bytes.size() - 2);
                eoi_at_cut = 1'b1;
            end else if (mode == 8 && str_bytes.size() > 2) begin
                idx = $urandom_range(str_bytes.size() - 2, 1);
                str_bytes[idx] = 8'($urandom_range(255));
            end
            for (i = 0; i <= cut; i++)
                send_byte(str_bytes[i], (i == cut) && eoi_at_cut);
        end
    endtask

    task automatic test_framing;
        send_byte("x", 1'b0);
        send_byte(CH_QUOTE, 1'b1);
        send_byte(CH_QUOTE, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(CH_QUOTE, 1'b1);
    endtask

    task automatic test_utf8_forms;
        send_byte(CH_QUOTE, 1'b0);
        send_byte(CH_BSLASH, 1'b0);
        send_byte(CH_U, 1'b0);
        send_byte("F", 1'b0);
        send_byte("f", 1'b0);
        send_byte("F", 1'b0);
        send_byte("f", 1'b0);
        send_byte(CH_BSLASH, 1'b0);
        send_byte(CH_U, 1'b0);
        send_byte("0", 1'b0);
        send_byte("7", 1'b0);
        send_byte("f", 1'b0);
        send_byte("F", 1'b0);
        send_byte(CH_QUOTE, 1'b0);
    endtask

    task automatic test_bad_input;
        send_byte(CH_QUOTE, 1'b0);
        send_byte(CH_BSLASH, 1'b0);
        send_byte("q", 1'b0);
        send_byte(CH_QUOTE, 1'b0);
        send_byte(CH_BSLASH, 1'b0);
        send_byte(CH_U, 1'b0);
        send_byte("g", 1'b0);
        send_byte(CH_QUOTE, 1'b0);
        send_byte("a", 1'b1);
    endtask

    task automatic test_random_stream(input int sender_pct, input int receiver_pct,
                                      input int count);
        int start;
        send_idle_pct = sender_pct;
        recv_idle_pct = receiver_pct;
        start = bytes_sent;
        while (bytes_sent - start < count) send_random_string();
        drain_results();
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (expected_rows.size() == 0) begin
                $error("unexpected result: tdata %h tuser %b tlast %b",
                       m_axis_tdata, m_axis_tuser, m_axis_tlast);
                error_cnt++;
            end else begin
                exp_row = expected_rows.pop_front();
                if (m_axis_tdata[7:0] !== exp_row.out_byte) begin
                    $error("out_byte: expected %h, actual %h",
                           exp_row.out_byte, m_axis_tdata[7:0]);
                    error_cnt++;
                end
                if (m_axis_tuser !== exp_row.byte_valid) begin
                    $error("byte_valid: expected %b, actual %b",
                           exp_row.byte_valid, m_axis_tuser);
                    error_cnt++;
                end
                if (m_axis_tdata[9:8] !== exp_row.status) begin
                    $error("status: expected %0d, actual %0d",
                           exp_row.status, m_axis_tdata[9:8]);
                    error_cnt++;
                end
                if (m_axis_tlast !== exp_row.run_last) begin
                    $error("run_last: expected %b, actual %b",
                           exp_row.run_last, m_axis_tlast);
                    error_cnt++;
                end
            end
        end
    end

    initial begin
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = 8'h00;
        s_axis_tlast  = 1'b0;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        send_idle_pct = 17;
        recv_idle_pct = 60;
        test_framing();
        drain_results();
        test_utf8_forms();
        drain_results();
        test_bad_input();
        drain_results();

        test_random_stream(17, 60, 65);
        test_random_stream(60, 17, 65);
        test_random_stream(0, 0, 55);

        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (error_cnt == 0 && expected_rows.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
